// File: sv/wsag_pkg.sv
// Shared types and constants for the wind sample averaging and gust block.
// Holds the channel payload structs, queue job type, register indexes,
// back-end sequencer states and the fixed arithmetic constants.
package wsag_pkg;

    // Ring of published speeds
    localparam int GUST_DEPTH = 32;
    localparam int RING_AW    = (GUST_DEPTH > 1) ? $clog2(GUST_DEPTH) : 1;
    localparam int FILL_W     = $clog2(GUST_DEPTH + 1);

    // Field widths
    localparam int CODE_W   = 12;
    localparam int MV_W     = 12;
    localparam int SUM_W    = 28;
    localparam int COUNT_W  = 16;
    localparam int SENS_W   = 13;
    localparam int SPEED_W  = 17;
    localparam int KMH_W    = 19;
    localparam int DIVF_W   = 3;
    localparam int SPM_W    = 4;
    localparam int DEAD_W   = 16;
    localparam int SPAN_W   = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Mean of 12-bit values always fits 12 bits, so 12 restoring steps do
    localparam int DIV_STEPS = CODE_W;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    // speed * 36 / 10 through a reciprocal: floor(x * ceil(2^27/10) >> 27)
    localparam int X36_W     = 23;
    localparam int RECIP_W   = 24;
    localparam logic [RECIP_W-1:0] KMH_RECIP = 24'd13421773;
    localparam int KMH_SHIFT = 27;

    // Publish queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Register reset values
    localparam logic [DIVF_W-1:0] DIVF_RESET = 3'd3;
    localparam logic [SPM_W-1:0]  SPM_RESET  = 4'd6;
    localparam logic [SENS_W-1:0] SMAX_RESET = 13'd5000;
    localparam logic [DEAD_W-1:0] DEAD_RESET = 16'd150;
    localparam logic [SPAN_W-1:0] SPAN_RESET = 6'd30;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIVIDER_FACTOR = 3'd0,
        CFG_SPEED_PER_MV   = 3'd1,
        CFG_SENSOR_MAX_MV  = 3'd2,
        CFG_DEADBAND_SPEED = 3'd3,
        CFG_GUST_SPAN      = 3'd4
    } cfg_idx_t;

    typedef enum logic {
        KIND_SAMPLE  = 1'b0,
        KIND_PUBLISH = 1'b1
    } kind_t;

    typedef struct packed {
        logic [0:0]        kind;
        logic [CODE_W-1:0] raw_code;
        logic [MV_W-1:0]   sample_mv;
    } sample_t;

    typedef struct packed {
        logic [CODE_W-1:0]  average_code;
        logic [MV_W-1:0]    average_mv;
        logic [SENS_W-1:0]  sensor_mv;
        logic [SPEED_W-1:0] speed_mm_s;
        logic [KMH_W-1:0]   speed_kmh_milli;
        logic [KMH_W-1:0]   gust_kmh_milli;
    } result_t;

    typedef struct packed {
        logic [SUM_W-1:0]   code_sum;
        logic [SUM_W-1:0]   mv_sum;
        logic [COUNT_W-1:0] sample_count;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_DIV,
        B_SENS,
        B_SPEED,
        B_KMH36,
        B_KMH,
        B_WRITE,
        B_PEAK,
        B_DONE
    } back_state_t;

endpackage

// File: sv/wsag_queue.sv
// Short FIFO of publish jobs between the front and back ends.
// Depends on wsag_pkg for job_t, q_status_t and the queue depth.
module wsag_queue
    import wsag_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  job_t      push_job,
    input  logic      pop,
    output job_t      head_job,
    output q_status_t status
);

    job_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] cnt_reg, cnt_next;

    function automatic logic [QUEUE_AW-1:0] ptr_inc(input logic [QUEUE_AW-1:0] p);
        if (p == QUEUE_AW'(QUEUE_DEPTH - 1))
            ptr_inc = '0;
        else
            ptr_inc = p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    assign head_job     = entry_reg[rd_ptr_reg];
    assign status.full  = (cnt_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign status.empty = (cnt_reg == '0);

endmodule

// File: sv/wsag_front.sv
// Front end: accepts sample and publish transactions, keeps the running sums.
// A publish with samples hands the sums to the job queue. Uses wsag_pkg.
module wsag_front
    import wsag_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      sample_valid,
    output logic      sample_stall,
    input  sample_t   sample,
    input  q_status_t q_status,
    output logic      push,
    output job_t      push_job
);

    logic [SUM_W-1:0]   code_sum_reg, code_sum_next;
    logic [SUM_W-1:0]   mv_sum_reg, mv_sum_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               accept;

    // Hold everything off while the queue cannot take a publish
    assign sample_stall = q_status.full;
    assign accept       = sample_valid && !sample_stall;

    always_comb
    begin
        code_sum_next = code_sum_reg;
        mv_sum_next   = mv_sum_reg;
        count_next    = count_reg;
        push          = 1'b0;
        if (accept)
        begin
            if (sample.kind == KIND_SAMPLE)
            begin
                // Drop samples once the count is saturated
                if (count_reg != COUNT_MAX)
                begin
                    code_sum_next = code_sum_reg + SUM_W'(sample.raw_code);
                    mv_sum_next   = mv_sum_reg + SUM_W'(sample.sample_mv);
                    count_next    = count_reg + 1'b1;
                end
            end
            else if (count_reg != '0)
            begin
                push          = 1'b1;
                code_sum_next = '0;
                mv_sum_next   = '0;
                count_next    = '0;
            end
        end
    end

    assign push_job.code_sum     = code_sum_reg;
    assign push_job.mv_sum       = mv_sum_reg;
    assign push_job.sample_count = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_sum_reg <= '0;
            mv_sum_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            code_sum_reg <= code_sum_next;
            mv_sum_reg   <= mv_sum_next;
            count_reg    <= count_next;
        end
    end

endmodule

// File: sv/wsag_back.sv
// Back end: divides the sums, scales to speed, updates the speed ring and
// walks it for the gust peak. Holds the configuration registers. Uses wsag_pkg.
module wsag_back
    import wsag_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  q_status_t             q_status,
    input  job_t                  head_job,
    output logic                  pop,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result
);

    localparam int CMP_W = (SPAN_W > FILL_W) ? SPAN_W : FILL_W;
    localparam int PROD_W = MV_W + DIVF_W;

    // Configuration
    logic [DIVF_W-1:0] divf_reg;
    logic [SPM_W-1:0]  spm_reg;
    logic [SENS_W-1:0] smax_reg;
    logic [DEAD_W-1:0] dead_reg;
    logic [SPAN_W-1:0] span_cfg_reg;

    back_state_t state_reg, state_next;

    // Divider
    logic [COUNT_W-1:0] div_reg;
    logic [COUNT_W-1:0] code_rem_reg, mv_rem_reg;
    logic [CODE_W-1:0]  code_lo_reg;
    logic [MV_W-1:0]    mv_lo_reg;
    logic [DIV_CW-1:0]  step_reg;
    logic [COUNT_W:0]   code_step, mv_step;

    // Scaling pipeline
    logic [PROD_W-1:0]            prod_reg;
    logic [SENS_W-1:0]            sens_clamp;
    logic [SENS_W-1:0]            sens_reg;
    logic [SPEED_W-1:0]           speed_raw_reg;
    logic [SPEED_W-1:0]           speed_db;
    logic [SPEED_W-1:0]           speed_reg;
    logic [X36_W-1:0]             x36_reg;
    logic [X36_W+RECIP_W-1:0]     recip_prod;
    logic [KMH_W-1:0]             kmh_reg;

    // Ring and peak walk
    logic [KMH_W-1:0]   ring [GUST_DEPTH];
    logic [KMH_W-1:0]   rd_data_reg;
    logic [RING_AW-1:0] head_reg;
    logic [RING_AW-1:0] ptr_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_new;
    logic [FILL_W-1:0]  span_reg;
    logic [FILL_W-1:0]  issued_reg;
    logic [CMP_W-1:0]   span_ext, fill_ext;
    logic               rd_pend_reg;
    logic [KMH_W-1:0]   peak_reg;

    logic               mem_we;
    logic               rd_en;
    logic               load_out;

    function automatic logic [COUNT_W:0] div_step(
        input logic [COUNT_W-1:0] rem,
        input logic               nbit,
        input logic [COUNT_W-1:0] dvs
    );
        logic [COUNT_W:0] t;
        t = {rem, nbit};
        if (t >= {1'b0, dvs})
            div_step = {COUNT_W'(t - {1'b0, dvs}), 1'b1};
        else
            div_step = {t[COUNT_W-1:0], 1'b0};
    endfunction

    function automatic logic [RING_AW-1:0] ring_inc(input logic [RING_AW-1:0] p);
        if (p == RING_AW'(GUST_DEPTH - 1))
            ring_inc = '0;
        else
            ring_inc = p + 1'b1;
    endfunction

    function automatic logic [RING_AW-1:0] ring_dec(input logic [RING_AW-1:0] p);
        if (p == '0)
            ring_dec = RING_AW'(GUST_DEPTH - 1);
        else
            ring_dec = p - 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divf_reg     <= DIVF_RESET;
            spm_reg      <= SPM_RESET;
            smax_reg     <= SMAX_RESET;
            dead_reg     <= DEAD_RESET;
            span_cfg_reg <= SPAN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_DIVIDER_FACTOR: divf_reg     <= cfg_data[DIVF_W-1:0];
                CFG_SPEED_PER_MV:   spm_reg      <= cfg_data[SPM_W-1:0];
                CFG_SENSOR_MAX_MV:  smax_reg     <= cfg_data[SENS_W-1:0];
                CFG_DEADBAND_SPEED: dead_reg     <= cfg_data[DEAD_W-1:0];
                CFG_GUST_SPAN:      span_cfg_reg <= cfg_data[SPAN_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
                if (!q_status.empty)
                    state_next = B_DIV;
            B_DIV:
                if (step_reg == DIV_CW'(DIV_STEPS - 1))
                    state_next = B_SENS;
            B_SENS:  state_next = B_SPEED;
            B_SPEED: state_next = B_KMH36;
            B_KMH36: state_next = B_KMH;
            B_KMH:   state_next = B_WRITE;
            B_WRITE: state_next = B_PEAK;
            B_PEAK:
                if (issued_reg == span_reg && !rd_pend_reg)
                    state_next = B_DONE;
            B_DONE:
                if (!result_valid || !result_stall)
                    state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        mem_we   = 1'b0;
        rd_en    = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            B_IDLE:  pop      = !q_status.empty;
            B_WRITE: mem_we   = 1'b1;
            B_PEAK:  rd_en    = (issued_reg != span_reg);
            B_DONE:  load_out = !result_valid || !result_stall;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= B_IDLE;
        else
            state_reg <= state_next;
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    assign code_step = div_step(code_rem_reg, code_lo_reg[CODE_W-1], div_reg);
    assign mv_step   = div_step(mv_rem_reg, mv_lo_reg[MV_W-1], div_reg);

    assign sens_clamp = (prod_reg > PROD_W'(smax_reg)) ? smax_reg : prod_reg[SENS_W-1:0];
    assign speed_db   = (speed_raw_reg < SPEED_W'(dead_reg)) ? '0 : speed_raw_reg;
    assign recip_prod = (X36_W + RECIP_W)'(x36_reg) * (X36_W + RECIP_W)'(KMH_RECIP);

    assign fill_new = (fill_reg == FILL_W'(GUST_DEPTH)) ? fill_reg : fill_reg + 1'b1;
    assign span_ext = CMP_W'(span_cfg_reg);
    assign fill_ext = CMP_W'(fill_new);

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                // Upper dividend bits are already below the count
                div_reg      <= head_job.sample_count;
                code_rem_reg <= head_job.code_sum[SUM_W-1 -: COUNT_W];
                code_lo_reg  <= head_job.code_sum[CODE_W-1:0];
                mv_rem_reg   <= head_job.mv_sum[SUM_W-1 -: COUNT_W];
                mv_lo_reg    <= head_job.mv_sum[MV_W-1:0];
                step_reg     <= '0;
            end
            B_DIV:
            begin
                code_rem_reg <= code_step[COUNT_W:1];
                code_lo_reg  <= {code_lo_reg[CODE_W-2:0], code_step[0]};
                mv_rem_reg   <= mv_step[COUNT_W:1];
                mv_lo_reg    <= {mv_lo_reg[MV_W-2:0], mv_step[0]};
                step_reg     <= step_reg + 1'b1;
            end
            B_SENS:
                prod_reg <= PROD_W'(mv_lo_reg) * PROD_W'(divf_reg);
            B_SPEED:
            begin
                sens_reg      <= sens_clamp;
                speed_raw_reg <= SPEED_W'(sens_clamp) * SPEED_W'(spm_reg);
            end
            B_KMH36:
            begin
                speed_reg <= speed_db;
                x36_reg   <= (X36_W'(speed_db) << 5) + (X36_W'(speed_db) << 2);
            end
            B_KMH:
                kmh_reg <= recip_prod[KMH_SHIFT +: KMH_W];
            B_WRITE:
            begin
                ptr_reg    <= head_reg;
                span_reg   <= (span_ext < fill_ext) ? span_ext[FILL_W-1:0]
                                                    : fill_ext[FILL_W-1:0];
                issued_reg <= '0;
                peak_reg   <= '0;
            end
            B_PEAK:
            begin
                if (rd_en)
                begin
                    ptr_reg    <= ring_dec(ptr_reg);
                    issued_reg <= issued_reg + 1'b1;
                end
                if (rd_pend_reg && rd_data_reg > peak_reg)
                    peak_reg <= rd_data_reg;
            end
            default: ;
        endcase
    end

    // Ring pointers and read tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            fill_reg    <= '0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= rd_en;
            if (mem_we)
            begin
                head_reg <= ring_inc(head_reg);
                fill_reg <= fill_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring[head_reg] <= kmh_reg;
        if (rd_en)
            rd_data_reg <= ring[ptr_reg];
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid <= 1'b0;
        else if (load_out)
            result_valid <= 1'b1;
        else if (!result_stall)
            result_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            result.average_code    <= code_lo_reg;
            result.average_mv      <= mv_lo_reg;
            result.sensor_mv       <= sens_reg;
            result.speed_mm_s      <= speed_reg;
            result.speed_kmh_milli <= kmh_reg;
            result.gust_kmh_milli  <= peak_reg;
        end
    end

endmodule

// File: sv/wind_sample_average_and_gust.sv
// Top level of the wind sample averaging and gust block.
// Instantiates wsag_front, wsag_queue and wsag_back; uses wsag_pkg.
//
// A sample transaction only updates the running sums, so samples stream at
// one per cycle; the input stalls only while the publish queue is full. A
// publish with samples is queued (two deep) and carried out by the back end:
// 12 restoring divide steps (both means in parallel), four scaling stages,
// one ring write, then a walk of one ring entry per cycle over the searched
// span (the ring memory has a single read port), then a load of the result
// register once it is free. The user must write configuration through the
// plain write port while no publish is in flight; the block does not enforce
// this. The speed ring needs no clearing pass after reset.
module wind_sample_average_and_gust
    import wsag_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  sample_t               sample,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    q_status_t q_status;
    logic      push;
    logic      pop;
    job_t      push_job;
    job_t      head_job;

    wsag_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .q_status     (q_status),
        .push         (push),
        .push_job     (push_job)
    );

    wsag_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    wsag_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_status     (q_status),
        .head_job     (head_job),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// File: sv/wsag_checker.sv
// Port-level checker for wind_sample_average_and_gust, bound to the top level.
// Shadows the configuration writes it needs; uses wsag_pkg.
module wsag_checker
    import wsag_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cfg_write,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data,
    input logic                  result_valid,
    input logic                  result_stall,
    input result_t               result
);

    logic [SENS_W-1:0] smax_reg;
    logic [DEAD_W-1:0] dead_reg;
    logic [SPAN_W-1:0] span_reg;
    logic [X36_W-1:0]  sp36;
    logic [X36_W-1:0]  kmh10;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smax_reg <= SMAX_RESET;
            dead_reg <= DEAD_RESET;
            span_reg <= SPAN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SENSOR_MAX_MV:  smax_reg <= cfg_data[SENS_W-1:0];
                CFG_DEADBAND_SPEED: dead_reg <= cfg_data[DEAD_W-1:0];
                CFG_GUST_SPAN:      span_reg <= cfg_data[SPAN_W-1:0];
                default: ;
            endcase
        end
    end

    assign sp36  = X36_W'(result.speed_mm_s) * X36_W'(36);
    assign kmh10 = X36_W'(result.speed_kmh_milli) * X36_W'(10);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_gust: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && span_reg != '0 |->
            result.gust_kmh_milli >= result.speed_kmh_milli)
        else $error("gust below current speed");

    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.sensor_mv <= smax_reg)
        else $error("sensor voltage above clamp");

    a_deadband: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.speed_mm_s == '0 || result.speed_mm_s >= SPEED_W'(dead_reg))
        else $error("speed inside deadband");

    a_kmh: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> kmh10 <= sp36 && sp36 < kmh10 + X36_W'(10))
        else $error("km/h conversion off");

endmodule

bind wind_sample_average_and_gust wsag_checker u_wsag_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
